[design/rmrd_pkg.sv]
// Shared types and constants for the register map range decoder.
// Holds the descriptor layout, command and status codes and register indexes.
// Depends on nothing; imported by register_map_range_decoder_top and its testbench.
package rmrd_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;
  localparam int IN_DAT_W  = 64;
  localparam int OUT_DAT_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BAD   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DENIED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_SWAP      = 2'd1;

  typedef struct packed {
    logic [15:0] base;
    logic [1:0]  size_code;
    logic        is_block;
    logic [15:0] elements;
    logic        readable;
    logic        writable;
  } desc_t;

  // Shift that turns an element count into words: one, two or four words.
  function automatic logic [1:0] size_shift(input logic [1:0] code);
    logic [1:0] sh;
    case (code)
      2'd0:    sh = 2'd0;
      2'd1:    sh = 2'd1;
      default: sh = 2'd2;
    endcase
    return sh;
  endfunction

endpackage

[design/register_map_range_decoder_top.sv]
// Register map range decoder: descriptor memory, scan sequencer and result stage.
// Depends on rmrd_pkg for the descriptor type, codes and register indexes.
//
// A load or undefined command goes straight to the result stage. A read or write query scans
// entries 0 to n-1 in order, n = min(entries_in_use, TABLE_ENTRIES), one entry a cycle,
// and stops at the first that covers the address. A new transfer is taken only when idle,
// after the last result is registered. A result waiting at the output holds the next item in
// its last step. Synchronous reset clears the sequencer, output valid and both cfg registers.
module register_map_range_decoder_top #(
  parameter int TABLE_ENTRIES = rmrd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // address, word_count, slot, entry_base, entry_size_code, entry_is_block,
  // entry_elements, entry_readable, entry_writable
  input  logic [rmrd_pkg::IN_DAT_W-1:0]   in_tdata,
  // command
  input  logic [rmrd_pkg::CMD_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit_entry, element_index, word_offset, word_lane, words_taken, zero padding
  output logic [rmrd_pkg::OUT_DAT_W-1:0]  out_tdata,
  // status
  output logic [rmrd_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rmrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmrd_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import rmrd_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int N_W   = ($clog2(TABLE_ENTRIES + 1) > 5) ? $clog2(TABLE_ENTRIES + 1) : 5;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  desc_t mem [TABLE_ENTRIES];
  desc_t q_r;

  logic [1:0]          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [15:0]         addr_r, addr_nxt;
  logic [6:0]          count_r, count_nxt;
  logic [3:0]          slot_r, slot_nxt;
  logic [N_W-1:0]      n_r, n_nxt;
  logic [N_W-1:0]      cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  desc_t               hit_r, hit_nxt;
  logic                found_r, found_nxt;
  logic [4:0]          eiu_r, eiu_nxt;
  logic                swap_r, swap_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DAT_W-1:0] out_data_r, out_data_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                in_fire, cfg_fire, out_free;
  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  desc_t               wr_desc;
  logic [31:0]         slot_ext, hit_ext;
  logic [N_W-1:0]      eiu_ext;

  logic [1:0]          q_sh;
  logic [17:0]         q_span;
  logic [18:0]         q_end;
  logic                q_cov;

  logic [1:0]          h_sh, h_mask, h_off, h_lane;
  logic [15:0]         h_rel, h_ix;
  logic [2:0]          h_w, h_take;
  logic [STATUS_W-1:0] h_status;
  logic [STATUS_W-1:0] res_status;
  logic [3:0]          res_hit;
  logic [15:0]         res_ix;
  logic [1:0]          res_off, res_lane;
  logic [2:0]          res_take;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  assign slot_ext = 32'(in_tdata[26:23]);
  assign wr_en    = in_fire && (in_tuser == CMD_LOAD) && (slot_ext < TABLE_ENTRIES);
  assign wr_addr  = slot_ext[IDX_W-1:0];
  assign wr_desc  = '{base: in_tdata[42:27], size_code: in_tdata[44:43],
                      is_block: in_tdata[45], elements: in_tdata[61:46],
                      readable: in_tdata[62], writable: in_tdata[63]};
  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign eiu_ext  = N_W'(eiu_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_desc;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Range check on the entry just read.
  always_comb begin
    q_sh   = size_shift(q_r.size_code);
    q_span = q_r.is_block ? ({2'b00, q_r.elements} << q_sh) : (18'd1 << q_sh);
    q_end  = {3'b000, q_r.base} + {1'b0, q_span};
    q_cov  = (addr_r == q_r.base) ||
             ((addr_r > q_r.base) && ({3'b000, addr_r} < q_end));
  end

  // Element arithmetic on the matching entry.
  always_comb begin
    h_sh   = size_shift(hit_r.size_code);
    h_w    = 3'd1 << h_sh;
    h_mask = h_w[1:0] - 2'd1;
    h_rel  = addr_r - hit_r.base;
    h_ix   = h_rel >> h_sh;
    h_off  = h_rel[1:0] & h_mask;
    h_lane = (swap_r && (h_sh != 2'd0)) ? (h_mask - h_off) : h_off;
    h_take = h_w - {1'b0, h_off};
    if (count_r < {4'b0000, h_take}) begin
      h_take = count_r[2:0];
    end
    if (cmd_r == CMD_READ) begin
      h_status = ((count_r == 7'd0) || !hit_r.readable) ? ST_DENIED : ST_OK;
    end else if ((count_r == 7'd0) || !hit_r.writable) begin
      h_status = ST_DENIED;
    end else if (count_r < {4'b0000, h_w}) begin
      h_status = ST_SHORT;
    end else begin
      h_status = ST_OK;
    end
  end

  assign hit_ext = 32'(hit_idx_r);

  always_comb begin
    res_status = ST_OK;
    res_hit    = 4'd0;
    res_ix     = 16'd0;
    res_off    = 2'd0;
    res_lane   = 2'd0;
    res_take   = 3'd0;
    if (cmd_r == CMD_LOAD) begin
      res_hit = slot_r;
    end else if (cmd_r == CMD_BAD) begin
      res_status = ST_DENIED;
    end else if (!found_r) begin
      res_status = ST_NO_MATCH;
    end else begin
      res_status = h_status;
      res_hit    = hit_ext[3:0];
      res_ix     = h_ix;
      res_off    = h_off;
      res_lane   = h_lane;
      res_take   = (h_status == ST_OK) ? h_take : 3'd0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    hit_idx_nxt    = hit_idx_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    eiu_nxt        = eiu_r;
    swap_nxt       = swap_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;

    if (cfg_fire) begin
      if (cfg_index == CFG_ENTRIES_IN_USE) begin
        eiu_nxt = cfg_wdata;
      end else if (cfg_index == CFG_WORD_SWAP) begin
        swap_nxt = cfg_wdata[0];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_tuser;
          addr_nxt  = in_tdata[15:0];
          count_nxt = in_tdata[22:16];
          slot_nxt  = in_tdata[26:23];
          n_nxt     = (eiu_ext > N_W'(TABLE_ENTRIES)) ? N_W'(TABLE_ENTRIES) : eiu_ext;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          if ((in_tuser == CMD_READ) || (in_tuser == CMD_WRITE)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_CALC;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && q_cov) begin
          found_nxt   = 1'b1;
          hit_nxt     = q_r;
          hit_idx_nxt = pend_idx_r;
          pend_nxt    = 1'b0;
          state_nxt   = S_CALC;
        end else if (cnt_r == n_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_CALC;
        end else begin
          rd_en        = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + N_W'(1);
        end
      end
      S_CALC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status;
          out_data_nxt   = {5'b00000, res_take, res_lane, res_off, res_ix, res_hit};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      eiu_r       <= 5'd0;
      swap_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      eiu_r       <= eiu_nxt;
      swap_r      <= swap_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    count_r      <= count_nxt;
    slot_r       <= slot_nxt;
    n_r          <= n_nxt;
    pend_idx_r   <= pend_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_r        <= hit_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

[tb/tb_register_map_range_decoder_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for register_map_range_decoder_top: loads descriptor tables,
// runs read and write queries under random flow control and checks each result.
// Depends on rmrd_pkg and the decoder RTL only.
module tb_register_map_range_decoder_top;
  import rmrd_pkg::*;

  localparam int DEPTH       = TABLE_ENTRIES_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 50;

  localparam logic [1:0] SIZE_ONE  = 2'd0;
  localparam logic [1:0] SIZE_TWO  = 2'd1;
  localparam logic [1:0] SIZE_FOUR = 2'd2;
  localparam logic [1:0] SIZE_ODD  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [6:0]  word_count;
    logic [3:0]  slot;
    logic [15:0] entry_base;
    logic [1:0]  entry_size_code;
    logic        entry_is_block;
    logic [15:0] entry_elements;
    logic        entry_readable;
    logic        entry_writable;
  } access_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  hit_entry;
    logic [15:0] element_index;
    logic [1:0]  word_offset;
    logic [1:0]  word_lane;
    logic [2:0]  words_taken;
  } decode_t;

  localparam int ACCESS_W = $bits(access_t);

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DAT_W-1:0]   in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DAT_W-1:0]  out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata  = '0;

  desc_t       desc_mem [DEPTH];
  logic [4:0]  entries_cfg = '0;
  logic        swap_cfg    = 1'b0;
  decode_t     expected_decodes [$];
  decode_t     want_r;

  bit          steady_flow = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned fail_count      = 0;
  int unsigned results_checked = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned loads_sent = 0, reads_sent = 0, writes_sent = 0, bad_sent = 0;

  register_map_range_decoder_top #(.TABLE_ENTRIES(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned elem_words(input logic [1:0] code);
    case (code)
      SIZE_ONE: return 1;
      SIZE_TWO: return 2;
      default:  return 4;
    endcase
  endfunction

  // Applies a load to the shadow table, or works out the outcome of a query.
  function automatic decode_t decode_address(input access_t it);
    decode_t     r;
    desc_t       d;
    int unsigned w, span, rel, n, k, take;
    bit          found;
    r = '0;
    found = 1'b0;
    if (it.command == CMD_LOAD) begin
      desc_mem[it.slot].base      = it.entry_base;
      desc_mem[it.slot].size_code = it.entry_size_code;
      desc_mem[it.slot].is_block  = it.entry_is_block;
      desc_mem[it.slot].elements  = it.entry_elements;
      desc_mem[it.slot].readable  = it.entry_readable;
      desc_mem[it.slot].writable  = it.entry_writable;
      r.hit_entry = it.slot;
    end else if (it.command == CMD_BAD) begin
      r.status = ST_DENIED;
    end else begin
      n = (entries_cfg > DEPTH) ? DEPTH : 32'(entries_cfg);
      for (k = 0; k < n; k++) begin
        d = desc_mem[k];
        w = elem_words(d.size_code);
        span = d.is_block ? d.elements * w : w;
        if (!found && (it.address == d.base ||
                       (it.address > d.base && it.address < d.base + span))) begin
          found = 1'b1;
          r.hit_entry = 4'(k);
        end
      end
      if (!found) begin
        r.status = ST_NO_MATCH;
      end else begin
        d = desc_mem[r.hit_entry];
        w = elem_words(d.size_code);
        rel = 32'(it.address) - 32'(d.base);
        r.element_index = 16'(rel / w);
        r.word_offset = 2'(rel % w);
        r.word_lane = (swap_cfg && w > 1) ? 2'(w - 1 - (rel % w)) : 2'(rel % w);
        take = w - (rel % w);
        if (it.word_count < take) take = 32'(it.word_count);
        if (it.command == CMD_READ) begin
          r.status = (it.word_count == 0 || !d.readable) ? ST_DENIED : ST_OK;
        end else if (it.word_count == 0 || !d.writable) begin
          r.status = ST_DENIED;
        end else if (it.word_count < w) begin
          r.status = ST_SHORT;
        end else begin
          r.status = ST_OK;
        end
        r.words_taken = (r.status == ST_OK) ? 3'(take) : 3'd0;
      end
    end
    return r;
  endfunction

  function automatic access_t random_item();
    access_t it;
    it = ACCESS_W'({$urandom, $urandom, $urandom});
    return it;
  endfunction

  // Query mostly aimed at or just past a descriptor in use, with small word counts.
  function automatic access_t aimed_query(input int unsigned n);
    access_t     it;
    int unsigned pick, k, w, span;
    it = random_item();
    pick = $urandom_range(0, 99);
    if (pick < 45) it.command = CMD_READ;
    else if (pick < 90) it.command = CMD_WRITE;
    else if (pick < 95) it.command = CMD_LOAD;
    else it.command = CMD_BAD;
    if (n > 0 && $urandom_range(0, 4) != 0) begin
      k = $urandom_range(0, n - 1);
      w = elem_words(desc_mem[k].size_code);
      span = desc_mem[k].is_block ? desc_mem[k].elements * w : w;
      if (span > 64) span = 64;
      it.address = 16'(desc_mem[k].base + $urandom_range(0, span + 1));
    end
    case ($urandom_range(0, 9))
      0:       it.word_count = 7'd0;
      8, 9:    it.word_count = 7'($urandom_range(0, 127));
      default: it.word_count = 7'($urandom_range(1, 5));
    endcase
    return it;
  endfunction

  task automatic send_item(input access_t it);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.command;
    in_tdata  <= {it.entry_writable, it.entry_readable, it.entry_elements, it.entry_is_block,
                  it.entry_size_code, it.entry_base, it.slot, it.word_count, it.address};
    do @(posedge clk); while (!in_tready);
    expected_decodes.push_back(decode_address(it));
    case (it.command)
      CMD_LOAD:  loads_sent++;
      CMD_READ:  reads_sent++;
      CMD_WRITE: writes_sent++;
      default:   bad_sent++;
    endcase
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ENTRIES_IN_USE) entries_cfg = val;
    else if (idx == CFG_WORD_SWAP) swap_cfg = val[0];
    @(posedge clk);
  endtask

  task automatic load_entry(input logic [3:0] slot, input logic [15:0] base,
                            input logic [1:0] size, input logic blk,
                            input logic [15:0] elements, input logic rd, input logic wr);
    access_t it;
    it = random_item();
    it.command = CMD_LOAD;
    it.slot = slot;
    it.entry_base = base;
    it.entry_size_code = size;
    it.entry_is_block = blk;
    it.entry_elements = elements;
    it.entry_readable = rd;
    it.entry_writable = wr;
    send_item(it);
  endtask

  task automatic query(input logic [1:0] cmd, input logic [15:0] addr, input logic [6:0] count);
    access_t it;
    it = random_item();
    it.command = cmd;
    it.address = addr;
    it.word_count = count;
    send_item(it);
  endtask

  // Sorted, mostly adjacent descriptors in every slot, now and then near the top of the map.
  task automatic load_layout();
    access_t     it;
    int unsigned cursor, w, span, i;
    cursor = ($urandom_range(0, 3) == 0) ? $urandom_range(65400, 65535) : $urandom_range(0, 4000);
    for (i = 0; i < DEPTH; i++) begin
      it = random_item();
      it.command = CMD_LOAD;
      it.slot = 4'(i);
      it.entry_base = 16'(cursor);
      it.entry_size_code = ($urandom_range(0, 9) == 0) ? SIZE_ODD : 2'($urandom_range(0, 2));
      it.entry_is_block = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0:       it.entry_elements = 16'd0;
        1:       it.entry_elements = 16'($urandom);
        default: it.entry_elements = 16'($urandom_range(1, 6));
      endcase
      it.entry_readable = $urandom_range(0, 3) != 0;
      it.entry_writable = $urandom_range(0, 3) != 0;
      w = elem_words(it.entry_size_code);
      span = it.entry_is_block ? it.entry_elements * w : w;
      cursor = (cursor + span + $urandom_range(0, 6)) & 32'hFFFF;
      send_item(it);
    end
  endtask

  task automatic test_empty_table();
    cfg_write(CFG_ENTRIES_IN_USE, 5'd0);
    cfg_write(CFG_WORD_SWAP, 5'd0);
    query(CMD_READ, 16'h0000, 7'd1);
    query(CMD_WRITE, 16'hFFFF, 7'd127);
    query(CMD_BAD, 16'h1234, 7'd3);
    drain_results();
  endtask

  task automatic test_descriptor_cases();
    load_entry(4'd0, 16'd100, SIZE_ONE, 1'b0, 16'd1, 1'b1, 1'b1);
    load_entry(4'd1, 16'd200, SIZE_TWO, 1'b0, 16'd1, 1'b1, 1'b0);
    load_entry(4'd2, 16'd300, SIZE_FOUR, 1'b1, 16'd3, 1'b1, 1'b1);
    load_entry(4'd3, 16'd400, SIZE_ODD, 1'b0, 16'd1, 1'b1, 1'b1);
    load_entry(4'd4, 16'd500, SIZE_TWO, 1'b1, 16'd0, 1'b1, 1'b1);
    load_entry(4'd5, 16'hFFF0, SIZE_FOUR, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    load_entry(4'd6, 16'h0000, SIZE_ONE, 1'b0, 16'd1, 1'b0, 1'b0);
    load_entry(4'd7, 16'hFFFF, SIZE_ONE, 1'b0, 16'd1, 1'b1, 1'b1);
    drain_results();
    cfg_write(CFG_ENTRIES_IN_USE, 5'd8);
    query(CMD_READ, 16'd100, 7'd1);
    query(CMD_WRITE, 16'd100, 7'd0);
    query(CMD_READ, 16'd201, 7'd5);
    query(CMD_WRITE, 16'd200, 7'd5);
    query(CMD_READ, 16'd302, 7'd127);
    query(CMD_WRITE, 16'd305, 7'd2);
    query(CMD_WRITE, 16'd309, 7'd4);
    query(CMD_READ, 16'd403, 7'd2);
    query(CMD_READ, 16'd500, 7'd3);
    query(CMD_READ, 16'd501, 7'd1);
    query(CMD_READ, 16'hFFFF, 7'd2);
    query(CMD_WRITE, 16'h0000, 7'd1);
    query(CMD_BAD, 16'd100, 7'd1);
    drain_results();
    cfg_write(CFG_WORD_SWAP, 5'b11111);
    query(CMD_READ, 16'd201, 7'd5);
    query(CMD_READ, 16'd302, 7'd127);
    query(CMD_READ, 16'hFFFF, 7'd2);
    drain_results();
  endtask

  task automatic test_random_phases();
    logic [4:0]  val;
    int unsigned p, q, n;
    for (p = 0; p < PHASES; p++) begin
      drain_results();
      val = 5'($urandom);
      val[0] = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      cfg_write(CFG_WORD_SWAP, val);
      case (p)
        0:       val = 5'(DEPTH);
        1:       val = 5'd1;
        5:       val = 5'($urandom_range(DEPTH + 1, 31));
        default: val = 5'($urandom_range(2, DEPTH - 1));
      endcase
      cfg_write(CFG_ENTRIES_IN_USE, val);
      n = (val > DEPTH) ? DEPTH : 32'(val);
      steady_flow = (p == 3);
      load_layout();
      for (q = 0; q < PHASE_ITEMS; q++) begin
        if (p == 2 && q == 10) begin
          hold_req = 1'b1;
          steady_flow = 1'b1;
        end
        if (p == 2 && q == 25) steady_flow = 1'b0;
        if (p == 4 && q == 25) drain_results();
        send_item(aimed_query(n));
      end
      steady_flow = 1'b0;
    end
    drain_results();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_decodes.size() == 0) begin
        $error("Result transfer arrived with no result expected.");
        fail_count++;
      end else begin
        want_r = expected_decodes.pop_front();
        check_field("status", want_r.status, out_tuser);
        check_field("hit_entry", want_r.hit_entry, out_tdata[3:0]);
        check_field("element_index", want_r.element_index, out_tdata[19:4]);
        check_field("word_offset", want_r.word_offset, out_tdata[21:20]);
        check_field("word_lane", want_r.word_lane, out_tdata[23:22]);
        check_field("words_taken", want_r.words_taken, out_tdata[26:24]);
        results_checked++;
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    bit          hold_done;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_descriptor_cases();
    test_random_phases();
    repeat (25) @(posedge clk);
    $display("Sent %0d loads, %0d reads, %0d writes and %0d undefined commands.",
             loads_sent, reads_sent, writes_sent, bad_sent);
    $display("Checked %0d results over an empty table, one to sixteen entries,", results_checked);
    $display("saturated entry counts and both word orders.");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
